>>> hdl/sndag_pkg.sv
`timescale 1ns / 1ps
package sndag_pkg;
  localparam int AddrW = 48;
  localparam int StrideW = 32;
  localparam int ShapeW = 44;
  localparam int TargetW = 13;
  localparam int NSlot = 4;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 48;

  localparam logic [1:0] ActReset = 2'd0;
  localparam logic [1:0] ActNext  = 2'd1;
  localparam logic [1:0] ActGoto  = 2'd2;
  localparam logic [1:0] ActUndef = 2'd3;

  localparam logic [CfgIdxW-1:0] RegDim0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDim1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDim2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDim3 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBase = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLast = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCont = 3'd6;
  localparam logic [CfgIdxW-1:0] RegElem = 3'd7;

  // Datapath commands issued by the controller.
  typedef enum logic [2:0] {
    CmdNone, CmdOrigin, CmdNext, CmdGotoInit, CmdGotoMul, CmdGotoAcc
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] dim;   // dimension worked on in goto steps
  } ctrl_t;

  typedef struct packed {
    logic [1:0] nd_m1; // dimensions in use minus one
  } stat_t;
endpackage

>>> hdl/sndag_ctrl.sv
`timescale 1ns / 1ps
module sndag_ctrl
  import sndag_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] action_i,
  input  logic       out_stall_i,
  input  stat_t      stat_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output ctrl_t      ctrl_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StAcc  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] dim_q, dim_d;
  logic       ovld_q, ovld_d;
  logic       take;

  // Output register is freed when taken; input accepted only when idle.
  assign in_stall_o  = (state_q != StIdle) || (ovld_q && out_stall_i);
  assign take        = in_valid_i && !in_stall_o;
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d = state_q;
    dim_d = dim_q;
    ovld_d = ovld_q && out_stall_i;
    ctrl_o.cmd = CmdNone;
    ctrl_o.dim = dim_q;
    unique case (state_q)
      StIdle: begin
        if (take) begin
          if (action_i == ActReset) begin
            ctrl_o.cmd = CmdOrigin;
            ovld_d = 1'b1;
          end else if (action_i == ActNext) begin
            ctrl_o.cmd = CmdNext;
            ovld_d = 1'b1;
          end else if (action_i == ActGoto) begin
            ctrl_o.cmd = CmdGotoInit;
            dim_d = stat_i.nd_m1;
            state_d = StMul;
          end else begin
            ovld_d = 1'b1;
          end
        end
      end
      StMul: begin
        ctrl_o.cmd = CmdGotoMul;
        state_d = StAcc;
      end
      StAcc: begin
        ctrl_o.cmd = CmdGotoAcc;
        if (dim_q == 2'd0) begin
          state_d = StIdle;
          ovld_d = 1'b1;
        end else begin
          dim_d = dim_q - 2'd1;
          state_d = StMul;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dim_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dim_q <= dim_d;
      ovld_q <= ovld_d;
    end
  end

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("accept while busy");
  a_no_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |-> !ovld_q) else $error("result during goto");
  a_mul_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |=> (state_q == StAcc)) else $error("bad goto seq");
`endif
endmodule

>>> hdl/sndag_dp.sv
`timescale 1ns / 1ps
module sndag_dp
  import sndag_pkg::*;
#(
  parameter int MaxDims = 4,
  parameter int ExtentBits = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  output stat_t                 stat_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic signed [TargetW-1:0] target_0_i,
  input  logic signed [TargetW-1:0] target_1_i,
  input  logic signed [TargetW-1:0] target_2_i,
  input  logic signed [TargetW-1:0] target_3_i,
  output logic [AddrW-1:0]      address_o,
  output logic [AddrW-1:0]      flat_index_o,
  output logic [ExtentBits-1:0] coord_0_o,
  output logic [ExtentBits-1:0] coord_1_o,
  output logic [ExtentBits-1:0] coord_2_o,
  output logic [ExtentBits-1:0] coord_3_o
);
  localparam int Ew = ExtentBits;

  logic [ShapeW-1:0] shape_q [NSlot];
  logic [AddrW-1:0]  wrap_q [NSlot];
  logic [AddrW-1:0]  base_q;
  logic [1:0]        last_q;
  logic              cont_q;
  logic [6:0]        elem_q;
  logic [Ew-1:0]     pos_q [NSlot];
  logic [Ew-1:0]     pos_d [NSlot];
  logic [AddrW-1:0]  addr_q, addr_d, lin_q, lin_d;
  logic [AddrW-1:0]  fac_q, fac_d;
  logic [AddrW-1:0]  pa_q, pa_d, pl_q, pl_d;
  logic [AddrW-1:0]  t_q, t_d;
  logic [1:0]        nd_m1;

  logic [Ew-1:0]      extm1 [NSlot];
  logic [AddrW-1:0]   stride [NSlot];
  logic [TargetW-1:0] tgt [NSlot];
  logic [TargetW-1:0] tgt_q [NSlot];
  logic [AddrW-1:0]   wrap_sub;
  logic               carry;

  logic signed [StrideW-1:0] cfg_stride;
  logic signed [Ew:0]        cfg_ext;
  logic signed [AddrW-1:0]   cfg_wrap;

  logic [TargetW-1:0]        t_sel;
  logic signed [TargetW-1:0] t_s;
  logic signed [StrideW-1:0] str_s;
  logic signed [AddrW-1:0]   pa_s;
  logic signed [AddrW:0]     fac_s;
  logic signed [AddrW:0]     pl_s;

  assign tgt[0] = target_0_i;
  assign tgt[1] = target_1_i;
  assign tgt[2] = target_2_i;
  assign tgt[3] = target_3_i;

  always_comb begin
    for (int i = 0; i < NSlot; i++) begin
      extm1[i] = shape_q[i][32 +: Ew];
      stride[i] = {{(AddrW-StrideW){shape_q[i][StrideW-1]}}, shape_q[i][StrideW-1:0]};
    end
  end

  // Wrap step stride*(extent-1) per dimension, formed when the shape is written.
  assign cfg_stride = cfg_data_i[StrideW-1:0];
  assign cfg_ext = {1'b0, cfg_data_i[32 +: Ew]};
  assign cfg_wrap = cfg_stride * cfg_ext;

  // Goto step operands: targets captured at accept, offset fits 13 bits signed.
  assign t_sel = tgt_q[ctrl_i.dim];
  assign t_s = t_sel[TargetW-1] ?
               t_sel + TargetW'(extm1[ctrl_i.dim]) + TargetW'(1) : t_sel;
  assign str_s = shape_q[ctrl_i.dim][StrideW-1:0];
  assign pa_s = t_s * str_s;
  assign fac_s = {1'b0, fac_q};
  assign pl_s = t_s * fac_s;

  // Dimensions in use, limited to MaxDims.
  always_comb begin
    if (32'(last_q) + 1 > MaxDims) nd_m1 = 2'(MaxDims - 1);
    else nd_m1 = last_q;
  end
  assign stat_o.nd_m1 = nd_m1;

  always_comb begin
    addr_d = addr_q;
    lin_d = lin_q;
    fac_d = fac_q;
    pa_d = pa_q;
    pl_d = pl_q;
    t_d = t_q;
    carry = 1'b0;
    for (int i = 0; i < NSlot; i++) pos_d[i] = pos_q[i];
    case (ctrl_i.cmd)
      CmdOrigin: begin
        addr_d = base_q;
        lin_d = '0;
        for (int i = 0; i < NSlot; i++) pos_d[i] = '0;
      end
      CmdNext: begin
        lin_d = lin_q + 1'b1;
        if (nd_m1 == 2'd0) begin
          addr_d = addr_q + stride[0];
          pos_d[0] = pos_q[0] + 1'b1;
        end else if (cont_q) begin
          addr_d = addr_q + AddrW'(elem_q);
        end else begin
          // Odometer: find the lowest-order digit that can step.
          carry = 1'b1;
          for (int i = NSlot - 1; i >= 0; i--) begin
            if (carry && i <= 32'(nd_m1) && !(nd_m1 == 2'd1 && i == 0)) begin
              if (pos_q[i] < extm1[i]) begin
                pos_d[i] = pos_q[i] + 1'b1;
                addr_d = addr_q + stride[i] - wrap_sub;
                carry = 1'b0;
              end else begin
                pos_d[i] = '0;
              end
            end
          end
          if (carry) begin
            if (nd_m1 == 2'd1) begin
              pos_d[0] = pos_q[0] + 1'b1;
              addr_d = addr_q + stride[0] - wrap_sub;
            end else begin
              addr_d = addr_q - wrap_sub;
            end
          end
        end
      end
      CmdGotoInit: begin
        addr_d = base_q;
        lin_d = '0;
        fac_d = AddrW'(1);
      end
      CmdGotoMul: begin
        t_d = {{(AddrW-TargetW){t_s[TargetW-1]}}, t_s};
        pa_d = pa_s;
        pl_d = pl_s[AddrW-1:0];
      end
      CmdGotoAcc: begin
        addr_d = addr_q + pa_q;
        lin_d = lin_q + pl_q;
        pos_d[ctrl_i.dim] = t_q[Ew-1:0];
        fac_d = fac_q * (AddrW'(extm1[ctrl_i.dim]) + 1'b1);
      end
      default: ;
    endcase
  end

  // Wrap correction: sum of the stored wrap steps over wrapped digits.
  logic [AddrW-1:0] wsum;
  always_comb begin
    logic c;
    wsum = '0;
    c = 1'b1;
    for (int i = NSlot - 1; i >= 0; i--) begin
      if (c && i <= 32'(nd_m1) && !(nd_m1 == 2'd1 && i == 0)) begin
        if (pos_q[i] < extm1[i]) c = 1'b0;
        else wsum = wsum + wrap_q[i];
      end
    end
  end
  assign wrap_sub = wsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSlot; i++) begin
        shape_q[i] <= '0;
        wrap_q[i] <= '0;
        pos_q[i] <= '0;
      end
      base_q <= '0;
      last_q <= '0;
      cont_q <= 1'b0;
      elem_q <= 7'd8;
      addr_q <= '0;
      lin_q <= '0;
      fac_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegBase: base_q <= cfg_data_i[AddrW-1:0];
          RegLast: last_q <= cfg_data_i[1:0];
          RegCont: cont_q <= cfg_data_i[0];
          RegElem: elem_q <= cfg_data_i[6:0];
          default: begin
            shape_q[cfg_index_i[1:0]] <= cfg_data_i[ShapeW-1:0];
            wrap_q[cfg_index_i[1:0]] <= cfg_wrap;
          end
        endcase
      end
      for (int i = 0; i < NSlot; i++) pos_q[i] <= pos_d[i];
      addr_q <= addr_d;
      lin_q <= lin_d;
      fac_q <= fac_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q <= pa_d;
    pl_q <= pl_d;
    t_q <= t_d;
    if (ctrl_i.cmd == CmdGotoInit) begin
      for (int i = 0; i < NSlot; i++) tgt_q[i] <= tgt[i];
    end
  end

  assign address_o = addr_q;
  assign flat_index_o = lin_q;
  assign coord_0_o = pos_q[0];
  assign coord_1_o = pos_q[1];
  assign coord_2_o = pos_q[2];
  assign coord_3_o = pos_q[3];

`ifndef SYNTHESIS
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.cmd == CmdOrigin) |=> (lin_q == '0)) else $error("origin index");
  a_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.cmd == CmdGotoInit) |=> (fac_q == AddrW'(1))) else $error("factor init");
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.cmd == CmdNext) |=> (lin_q == $past(lin_q) + 1'b1)) else $error("next index");
`endif
endmodule

>>> hdl/strided_nd_address_generator_core.sv
`timescale 1ns / 1ps
// Strided N-dimensional address generator.
// Reset/next: output in the cycle after accept, one per cycle unless stalled.
// Goto items: a multiply and an accumulate step per dimension in use.
// The shared goto multiply/accumulate step sets the goto rate.
// Asynchronous active-low reset clears coordinates, address, index; element size 8.
module strided_nd_address_generator_core
  import sndag_pkg::*;
#(
  parameter int MAX_DIMS = 4,
  parameter int EXTENT_BITS = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               action_i,
  input  logic signed [TargetW-1:0] target_0_i,
  input  logic signed [TargetW-1:0] target_1_i,
  input  logic signed [TargetW-1:0] target_2_i,
  input  logic signed [TargetW-1:0] target_3_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [AddrW-1:0]         address_o,
  output logic [AddrW-1:0]         flat_index_o,
  output logic [EXTENT_BITS-1:0]   coord_0_o,
  output logic [EXTENT_BITS-1:0]   coord_1_o,
  output logic [EXTENT_BITS-1:0]   coord_2_o,
  output logic [EXTENT_BITS-1:0]   coord_3_o
);
  ctrl_t ctrl;
  stat_t stat;

  // Controller sequences goto steps and owns the handshake.
  sndag_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .action_i, .out_stall_i,
    .stat_i(stat), .in_stall_o, .out_valid_o, .ctrl_o(ctrl)
  );

  // Datapath holds config, coordinates, address and index; the output
  // fields are its registers directly.
  sndag_dp #(.MaxDims(MAX_DIMS), .ExtentBits(EXTENT_BITS)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .target_0_i, .target_1_i, .target_2_i, .target_3_i,
    .address_o, .flat_index_o, .coord_0_o, .coord_1_o, .coord_2_o, .coord_3_o
  );
endmodule
